// ===== rtl/core/hvs_pkg.sv =====
// hvs_pkg: shared types and constants for the hypervolume-by-slicing block
// used by hvs_ctrl, hvs_datapath and hypervolume_by_slicing_top
package hvs_pkg;

    localparam int VOL_BITS    = 64;
    localparam int FIELD_BITS  = 16;
    localparam int CFG_BITS    = 3;
    localparam int MUL_CHUNK   = 16;
    localparam int MUL_STEPS   = VOL_BITS / MUL_CHUNK;
    localparam int MCW         = $clog2(MUL_STEPS);
    localparam int CIDX_BITS   = 2;
    localparam logic [CFG_BITS-1:0] NOBJ_RESET = 3'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOP,
        ST_SCAN_CLR,
        ST_SCAN,
        ST_EVAL,
        ST_SETUP,
        ST_MUL,
        ST_COMMIT,
        ST_EMIT
    } hvs_state_t;

    typedef struct packed {
        logic take_in;
        logic scan_clr;
        logic scan_rd;
        logic start_top;
        logic descend;
        logic ascend;
        logic mul_setup;
        logic base_part;
        logic mul_step;
        logic commit;
        logic emit;
    } hvs_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic at_base;
        logic at_top;
        logic mul_last;
        logic out_free;
    } hvs_status_t;

endpackage

// ===== rtl/core/hvs_ram.sv =====
// hvs_ram: generic single write port, single read port ram with registered read
// no dependencies
module hvs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/hvs_ctrl.sv =====
// hvs_ctrl: sequencer for intake, scans, slice recursion and result hand-off
// depends on hvs_pkg
module hvs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last_of_set,
    output logic                in_stall,
    input  hvs_pkg::hvs_status_t sts,
    output hvs_pkg::hvs_cmd_t   cmd
);
    import hvs_pkg::*;

    hvs_state_t state_reg;
    hvs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && last_of_set)
                begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP:      state_next = ST_SCAN_CLR;
            ST_SCAN_CLR: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!sts.found)
                begin
                    state_next = sts.at_top ? ST_EMIT : ST_SETUP;
                end
                else
                begin
                    state_next = sts.at_base ? ST_MUL : ST_SCAN_CLR;
                end
            end
            ST_SETUP:    state_next = ST_MUL;
            ST_MUL:
            begin
                if (sts.mul_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:   state_next = ST_SCAN_CLR;
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.take_in = in_valid;
            end
            ST_TOP:      cmd.start_top = 1'b1;
            ST_SCAN_CLR: cmd.scan_clr = 1'b1;
            ST_SCAN:     cmd.scan_rd = 1'b1;
            ST_EVAL:
            begin
                if (!sts.found)
                begin
                    cmd.ascend = !sts.at_top;
                end
                else if (sts.at_base)
                begin
                    cmd.base_part = 1'b1;
                end
                else
                begin
                    cmd.descend = 1'b1;
                end
            end
            ST_SETUP:    cmd.mul_setup = 1'b1;
            ST_MUL:      cmd.mul_step = 1'b1;
            ST_COMMIT:   cmd.commit = 1'b1;
            ST_EMIT:     cmd.emit = sts.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/hvs_datapath.sv =====
// hvs_datapath: point store, scan filter, per-level slice registers, multiplier
// depends on hvs_pkg and hvs_ram
module hvs_datapath #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_OBJ    = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [hvs_pkg::CFG_BITS-1:0]        cfg_wr_data,
    input  logic [hvs_pkg::FIELD_BITS-1:0]      coord_value,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [hvs_pkg::VOL_BITS-1:0]        volume,
    output logic                                overflow,
    input  hvs_pkg::hvs_cmd_t                   cmd,
    output hvs_pkg::hvs_status_t                sts
);
    import hvs_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_OBJ);
    localparam int RW = MAX_OBJ * COORD_BITS;
    localparam int PW = MUL_CHUNK + COORD_BITS;

    logic [CFG_BITS-1:0]   nobj_reg;
    logic [KW-1:0]         topk;
    logic [CW-1:0]         count_reg;
    logic [CIDX_BITS-1:0]  cidx_reg;
    logic                  sovf_reg;
    logic [COORD_BITS-1:0] row_reg [MAX_OBJ];
    logic [COORD_BITS-1:0] v;
    logic                  complete;
    logic                  full;
    logic [RW-1:0]         row_w;
    logic                  ram_we;
    logic                  ram_re;
    logic [RW-1:0]         ram_rdata;

    logic [CW-1:0]         addr_reg;
    logic                  rd_valid_reg;
    logic [COORD_BITS-1:0] min_reg;
    logic [COORD_BITS-1:0] max_reg;
    logic                  found_reg;
    logic                  member;
    logic [COORD_BITS-1:0] c [MAX_OBJ];

    logic [KW-1:0]         lvl_reg;
    logic [COORD_BITS-1:0] dist_reg   [MAX_OBJ];
    logic [COORD_BITS-1:0] height_reg [MAX_OBJ];
    logic [VOL_BITS-1:0]   vol_reg    [MAX_OBJ];
    logic [VOL_BITS-1:0]   part_reg;
    logic [COORD_BITS-1:0] diff_reg;
    logic [MCW-1:0]        mcnt_reg;
    logic [MUL_CHUNK-1:0]  chunk;
    logic [PW-1:0]         prod;
    logic [VOL_BITS-1:0]   prod_sh;

    logic                  out_valid_reg;
    logic [VOL_BITS-1:0]   volume_reg;
    logic                  ovf_out_reg;

    // objective count clamped to 2..MAX_OBJ, kept as index of last coordinate
    always_comb
    begin
        if (nobj_reg < 3'd2)
        begin
            topk = KW'(1);
        end
        else if (int'(nobj_reg) > MAX_OBJ)
        begin
            topk = KW'(MAX_OBJ - 1);
        end
        else
        begin
            topk = KW'(nobj_reg - 3'd1);
        end
    end

    assign v        = coord_value[COORD_BITS-1:0];
    assign complete = 3'(cidx_reg) >= 3'(topk);
    assign full     = count_reg == CW'(MAX_POINTS);
    assign ram_we   = cmd.take_in && !full && complete;
    assign ram_re   = cmd.scan_rd && (addr_reg < count_reg);

    always_comb
    begin
        for (int j = 0; j < MAX_OBJ; j++)
        begin
            row_w[j*COORD_BITS +: COORD_BITS] =
                (cidx_reg == CIDX_BITS'(j)) ? v : row_reg[j];
        end
    end

    hvs_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (row_w),
        .re    (ram_re),
        .raddr (addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // a point belongs to the current set if it is above the slice floor of
    // this level and every enclosing level
    always_comb
    begin
        member = 1'b1;
        for (int j = 0; j < MAX_OBJ; j++)
        begin
            c[j] = ram_rdata[j*COORD_BITS +: COORD_BITS];
            if (j >= int'(lvl_reg) && j <= int'(topk) && !(c[j] > dist_reg[j]))
            begin
                member = 1'b0;
            end
        end
    end

    assign chunk   = part_reg[MUL_CHUNK*int'(mcnt_reg) +: MUL_CHUNK];
    assign prod    = PW'(chunk) * PW'(diff_reg);
    assign prod_sh = VOL_BITS'(prod) << (MUL_CHUNK*int'(mcnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nobj_reg      <= NOBJ_RESET;
            count_reg     <= '0;
            cidx_reg      <= '0;
            sovf_reg      <= 1'b0;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            lvl_reg       <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                nobj_reg <= cfg_wr_data;
            end
            if (cmd.take_in)
            begin
                if (!full)
                begin
                    if (complete)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                else
                begin
                    sovf_reg <= 1'b1;
                end
                cidx_reg <= complete ? '0 : cidx_reg + CIDX_BITS'(1);
            end
            if (cmd.scan_clr)
            begin
                addr_reg     <= '0;
                rd_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (ram_re)
                begin
                    addr_reg <= addr_reg + CW'(1);
                end
                rd_valid_reg <= ram_re;
                if (rd_valid_reg && member)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.start_top)
            begin
                lvl_reg <= topk;
            end
            if (cmd.descend)
            begin
                lvl_reg <= lvl_reg - KW'(1);
            end
            if (cmd.ascend)
            begin
                lvl_reg <= lvl_reg + KW'(1);
            end
            if (cmd.mul_setup || cmd.base_part)
            begin
                mcnt_reg <= '0;
            end
            else if (cmd.mul_step)
            begin
                mcnt_reg <= mcnt_reg + MCW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                cidx_reg      <= '0;
                sovf_reg      <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in && !full)
        begin
            for (int j = 0; j < MAX_OBJ; j++)
            begin
                if (cidx_reg == CIDX_BITS'(j))
                begin
                    row_reg[j] <= v;
                end
            end
        end
        if (cmd.scan_clr)
        begin
            min_reg <= '1;
            max_reg <= '0;
        end
        else if (rd_valid_reg && member)
        begin
            if (c[lvl_reg] < min_reg)
            begin
                min_reg <= c[lvl_reg];
            end
            if (c[0] > max_reg)
            begin
                max_reg <= c[0];
            end
        end
        if (cmd.start_top)
        begin
            dist_reg[topk] <= '0;
            vol_reg[topk]  <= '0;
        end
        if (cmd.descend)
        begin
            height_reg[lvl_reg]         <= min_reg;
            dist_reg[lvl_reg - KW'(1)]  <= '0;
            vol_reg[lvl_reg - KW'(1)]   <= '0;
        end
        if (cmd.ascend)
        begin
            part_reg <= vol_reg[lvl_reg];
        end
        if (cmd.mul_setup)
        begin
            diff_reg <= height_reg[lvl_reg] - dist_reg[lvl_reg];
        end
        if (cmd.base_part)
        begin
            height_reg[lvl_reg] <= min_reg;
            part_reg            <= VOL_BITS'(max_reg);
            diff_reg            <= min_reg - dist_reg[lvl_reg];
        end
        if (cmd.mul_step)
        begin
            vol_reg[lvl_reg] <= vol_reg[lvl_reg] + prod_sh;
        end
        if (cmd.commit)
        begin
            dist_reg[lvl_reg] <= height_reg[lvl_reg];
        end
        if (cmd.emit)
        begin
            volume_reg  <= vol_reg[lvl_reg];
            ovf_out_reg <= sovf_reg;
        end
    end

    assign sts.scan_done = (addr_reg == count_reg) && !rd_valid_reg;
    assign sts.found     = found_reg;
    assign sts.at_base   = lvl_reg == KW'(1);
    assign sts.at_top    = lvl_reg == topk;
    assign sts.mul_last  = mcnt_reg == MCW'(MUL_STEPS - 1);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign volume    = volume_reg;
    assign overflow  = ovf_out_reg;

endmodule

// ===== rtl/core/hypervolume_by_slicing_top.sv =====
// hypervolume_by_slicing_top: dominated hypervolume of a point set by slicing
// depends on hvs_pkg, hvs_ctrl, hvs_datapath, hvs_ram
//
// usage:
//   input channel (in_valid/in_stall) carries one coordinate per request,
//   coordinates of a point in objective order; last_of_set marks the final
//   coordinate of the final point and starts the computation.
//   a request is taken every cycle while loading; after the final request
//   in_stall stays high until the result is placed in the output register.
//   computation: each slice costs one scan of the point store, a clear state
//   and then reads of every stored point through the single read port of the
//   store ram, an evaluate state, and where a slice closes the 64 x 16
//   multiply as four 16-bit partial products, a setup state on the way up and
//   a commit state; the total cost follows the number of distinct slice
//   heights at each level of the recursion.
//   output channel (out_valid/out_stall) holds volume and overflow until taken;
//   loading of the next set proceeds while a result waits, a new result waits
//   in the sequencer until the output register is free.
//   num_objectives is written through cfg_wr_en/cfg_wr_data while idle.
//   reset clears the counters, the handshake state and sets two objectives;
//   the point store needs no clearing.
module hypervolume_by_slicing_top #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_OBJ    = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hvs_pkg::CFG_BITS-1:0]    cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [hvs_pkg::FIELD_BITS-1:0]  coord_value,
    input  logic                            last_of_set,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hvs_pkg::VOL_BITS-1:0]    volume,
    output logic                            overflow
);
    import hvs_pkg::*;

    hvs_cmd_t    cmd;
    hvs_status_t sts;

    hvs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_of_set (last_of_set),
        .in_stall    (in_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    hvs_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_OBJ    (MAX_OBJ),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .coord_value (coord_value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .volume      (volume),
        .overflow    (overflow),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
